// ===== rtl/swpd_pkg.sv =====
// Shared types and constants for the sync-word packet deframer.
// Used by sync_word_packet_deframer_core; no dependencies.
`default_nettype none

package swpd_pkg;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_RESTART    = 3'd1,
      EV_BAD_SYNC   = 3'd2,
      EV_BAD_HEADER = 3'd3,
      EV_SPEED_DONE = 3'd4,
      EV_INIT_ERR   = 3'd5,
      EV_COMM_ERR   = 3'd6,
      EV_BAD_ERR    = 3'd7
   } event_type;

   localparam logic [7:0] SYNC_0     = 8'hAA;
   localparam logic [7:0] SYNC_1     = 8'hFF;
   localparam logic [7:0] SYNC_2     = 8'h00;
   localparam logic [7:0] SYNC_3     = 8'h55;
   localparam logic [7:0] HDR_SPEED  = 8'h53;  // 'S'
   localparam logic [7:0] HDR_ERROR  = 8'h45;  // 'E'
   localparam logic [7:0] ERR_INIT   = 8'h49;  // 'I'
   localparam logic [7:0] ERR_COMM   = 8'h43;  // 'C'

   function automatic logic [7:0] sync_byte(input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0:    b = SYNC_0;
         2'd1:    b = SYNC_1;
         2'd2:    b = SYNC_2;
         default: b = SYNC_3;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sync_word_packet_deframer_core.sv =====
// Sync-word packet deframer: hunts AA FF 00 55, parses 'S' speed and 'E' error packets.
// Depends on swpd_pkg.
`default_nettype none

// One beat in, one beat out. Each received byte is captured in an input register,
// the framing state is updated by one small combinational step, and the result is
// held in an output register. A new byte can be taken every cycle while the result is
// not stalled; while a result is stalled the input register still takes one more byte.
// rsp_speed_bits always shows the last complete speed word; rsp_speed_valid is high while
// the stored error code is zero.
module sync_word_packet_deframer_core
   import swpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_speed_bits,
   output logic             rsp_speed_valid,
   output logic [7:0]       rsp_error_code,
   output logic [2:0]       rsp_event_res
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        advance;

   phase_type   phase_ff, phase_in;
   logic [1:0]  sync_pos_ff, sync_pos_in;
   logic [1:0]  pay_pos_ff, pay_pos_in;
   logic        is_speed_ff, is_speed_in;
   logic [31:0] assembly_ff, assembly_in;
   logic [31:0] speed_word_ff, speed_word_in;
   logic [7:0]  error_byte_ff, error_byte_in;
   event_type   event_ff, event_in;
   logic        rsp_valid_ff;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      sync_pos_in   = sync_pos_ff;
      pay_pos_in    = pay_pos_ff;
      is_speed_in   = is_speed_ff;
      assembly_in   = assembly_ff;
      speed_word_in = speed_word_ff;
      error_byte_in = error_byte_ff;
      event_in      = EV_NONE;
      case (phase_ff)
         PH_HEADER: begin
            if (in_byte_ff == HDR_SPEED || in_byte_ff == HDR_ERROR) begin
               is_speed_in = (in_byte_ff == HDR_SPEED);
               pay_pos_in  = 2'd0;
               phase_in    = PH_PAYLOAD;
            end else begin
               event_in = EV_BAD_HEADER;
               phase_in = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            if (is_speed_ff) begin
               case (pay_pos_ff)
                  2'd0:    assembly_in[7:0]   = in_byte_ff;
                  2'd1:    assembly_in[15:8]  = in_byte_ff;
                  2'd2:    assembly_in[23:16] = in_byte_ff;
                  default: assembly_in[31:24] = in_byte_ff;
               endcase
               if (pay_pos_ff == 2'd3) begin
                  pay_pos_in    = 2'd0;
                  speed_word_in = assembly_in;
                  error_byte_in = 8'd0;
                  phase_in      = PH_HUNT;
                  event_in      = EV_SPEED_DONE;
               end else begin
                  pay_pos_in = pay_pos_ff + 2'd1;
               end
            end else begin
               error_byte_in = in_byte_ff;
               if (in_byte_ff == ERR_INIT) begin
                  event_in = EV_INIT_ERR;
               end else if (in_byte_ff == ERR_COMM) begin
                  event_in = EV_COMM_ERR;
               end else begin
                  event_in = EV_BAD_ERR;
               end
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (in_byte_ff == sync_byte(sync_pos_ff)) begin
               if (sync_pos_ff == 2'd3) begin
                  sync_pos_in = 2'd0;
                  phase_in    = PH_HEADER;
               end else begin
                  sync_pos_in = sync_pos_ff + 2'd1;
               end
            end else if (in_byte_ff == SYNC_0) begin
               sync_pos_in = 2'd1;
               event_in    = EV_RESTART;
            end else begin
               sync_pos_in = 2'd0;
               event_in    = EV_BAD_SYNC;
            end
         end
      endcase
   end

   // state registers only change together with a new result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         sync_pos_ff   <= 2'd0;
         pay_pos_ff    <= 2'd0;
         is_speed_ff   <= 1'b0;
         assembly_ff   <= 32'd0;
         speed_word_ff <= 32'd0;
         error_byte_ff <= 8'd0;
         event_ff      <= EV_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff      <= phase_in;
            sync_pos_ff   <= sync_pos_in;
            pay_pos_ff    <= pay_pos_in;
            is_speed_ff   <= is_speed_in;
            assembly_ff   <= assembly_in;
            speed_word_ff <= speed_word_in;
            error_byte_ff <= error_byte_in;
            event_ff      <= event_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_bits  = speed_word_ff;
   assign rsp_error_code  = error_byte_ff;
   assign rsp_speed_valid = (error_byte_ff == 8'd0);
   assign rsp_event_res   = event_ff;

   a_sync_pos_in_hunt: assert property (@(posedge clock) disable iff (reset)
      sync_pos_ff != 2'd0 |-> phase_ff == PH_HUNT)
      else $error("sync position set outside hunt");

   a_pay_pos_in_speed: assert property (@(posedge clock) disable iff (reset)
      pay_pos_ff != 2'd0 |-> (phase_ff == PH_PAYLOAD && is_speed_ff))
      else $error("payload position set outside speed payload");

   a_speed_done_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && event_ff == EV_SPEED_DONE) |-> error_byte_ff == 8'd0)
      else $error("speed packet left error code set");

   a_speed_done_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (event_ff == EV_SPEED_DONE || event_ff == EV_BAD_HEADER))
         |-> phase_ff == PH_HUNT)
      else $error("packet end did not return to hunt");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(speed_word_ff) && $stable(error_byte_ff))
      else $error("state moved while result stalled");

endmodule

`default_nettype wire
